/* rtl/super_2xsai_pixel_scaler_defines.svh */
// Assertion macros for the Super 2xSaI scaler.
// Included by modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef SUPER_2XSAI_PIXEL_SCALER_DEFINES_SVH
`define SUPER_2XSAI_PIXEL_SCALER_DEFINES_SVH
`ifndef SYNTHESIS
`define S2XS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("s2xs check failed");
`define S2XS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("s2xs check failed");
`else
`define S2XS_ASSERT_IMP(label, ante, cons)
`define S2XS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/s2xs_pkg.sv */
// Shared constants and types for the Super 2xSaI pixel scaler.
// No dependencies.
package s2xs_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 32;

	localparam int PORT_PIX_W  = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int ROW_WIDTH_W = 13;
	localparam int COL_W       = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_COLOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_LOW   = 3'd4;

	localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH     = 13'd640;
	localparam logic [CFG_DATA_W-1:0]  RST_HALF_COLOR    = 32'h00FE_FEFE;
	localparam logic [CFG_DATA_W-1:0]  RST_HALF_LOW      = 32'h0001_0101;
	localparam logic [CFG_DATA_W-1:0]  RST_QUARTER_COLOR = 32'h00FC_FCFC;
	localparam logic [CFG_DATA_W-1:0]  RST_QUARTER_LOW   = 32'h0003_0303;

	typedef struct packed {
		logic [ROW_WIDTH_W-1:0] row_width;
		logic [CFG_DATA_W-1:0]  half_color_mask;
		logic [CFG_DATA_W-1:0]  half_low_mask;
		logic [CFG_DATA_W-1:0]  quarter_color_mask;
		logic [CFG_DATA_W-1:0]  quarter_low_mask;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] column;
		logic             row_done;
	} emit_ctl_t;

endpackage

/* rtl/s2xs_cfg.sv */
// Configuration register file of the Super 2xSaI scaler.
// Depends on s2xs_pkg.
module s2xs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [s2xs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [s2xs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output s2xs_pkg::cfg_t                     cfg
);

	s2xs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width          <= s2xs_pkg::RST_ROW_WIDTH;
			cfg_q.half_color_mask    <= s2xs_pkg::RST_HALF_COLOR;
			cfg_q.half_low_mask      <= s2xs_pkg::RST_HALF_LOW;
			cfg_q.quarter_color_mask <= s2xs_pkg::RST_QUARTER_COLOR;
			cfg_q.quarter_low_mask   <= s2xs_pkg::RST_QUARTER_LOW;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				s2xs_pkg::CFG_ROW_WIDTH:
					cfg_q.row_width <= cfg_data[s2xs_pkg::ROW_WIDTH_W-1:0];
				s2xs_pkg::CFG_HALF_COLOR:    cfg_q.half_color_mask    <= cfg_data;
				s2xs_pkg::CFG_HALF_LOW:      cfg_q.half_low_mask      <= cfg_data;
				s2xs_pkg::CFG_QUARTER_COLOR: cfg_q.quarter_color_mask <= cfg_data;
				s2xs_pkg::CFG_QUARTER_LOW:   cfg_q.quarter_low_mask   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/s2xs_kernel.sv */
// Super 2xSaI edge rules: one 2x2 output block from a 4x4 pixel window.
// Pure combinational; depends on s2xs_pkg.
module s2xs_kernel #(
	parameter int PIXEL_BITS = s2xs_pkg::PIXEL_BITS_DEF
) (
	input  logic [15:0][PIXEL_BITS-1:0] win,
	input  s2xs_pkg::cfg_t              cfg,
	output logic [PIXEL_BITS-1:0]       p1a,
	output logic [PIXEL_BITS-1:0]       p1b,
	output logic [PIXEL_BITS-1:0]       p2a,
	output logic [PIXEL_BITS-1:0]       p2b
);

	localparam int PB = PIXEL_BITS;

	logic [PB-1:0] hm, hl, qm, ql;

	assign hm = cfg.half_color_mask[PB-1:0];
	assign hl = cfg.half_low_mask[PB-1:0];
	assign qm = cfg.quarter_color_mask[PB-1:0];
	assign ql = cfg.quarter_low_mask[PB-1:0];

	function automatic logic [PB-1:0] hmix(input logic [PB-1:0] a, input logic [PB-1:0] b,
		input logic [PB-1:0] m, input logic [PB-1:0] l);
		logic [PB-1:0] s;
		s = ((a & m) >> 1) + ((b & m) >> 1) + (a & b & l);
		return s;
	endfunction

	function automatic logic [PB-1:0] qmix(input logic [PB-1:0] a, input logic [PB-1:0] b,
		input logic [PB-1:0] c, input logic [PB-1:0] d,
		input logic [PB-1:0] m, input logic [PB-1:0] l);
		logic [PB+1:0] hi, lo, s;
		hi = {2'b00, (a & m) >> 2} + {2'b00, (b & m) >> 2}
			+ {2'b00, (c & m) >> 2} + {2'b00, (d & m) >> 2};
		lo = {2'b00, a & l} + {2'b00, b & l} + {2'b00, c & l} + {2'b00, d & l};
		s  = hi + {2'b00, lo[PB+1:2] & l};
		return s[PB-1:0];
	endfunction

	// +1 votes for a, -1 for b; a pair counts for b only when it misses a
	function automatic logic signed [2:0] vote(input logic [PB-1:0] a, input logic [PB-1:0] b,
		input logic [PB-1:0] c, input logic [PB-1:0] d);
		logic [1:0] xc, yc;
		logic signed [2:0] r;
		xc = {1'b0, a == c} + {1'b0, a == d};
		yc = {1'b0, (a != c) && (b == c)} + {1'b0, (a != d) && (b == d)};
		r  = 3'sd0;
		if (xc <= 2'd1) r = r + 3'sd1;
		if (yc <= 2'd1) r = r - 3'sd1;
		return r;
	endfunction

	logic signed [4:0] votes;
	logic              e96, e510;

	assign e96  = win[9] == win[6];
	assign e510 = win[5] == win[10];

	assign votes = 5'(vote(win[6], win[5], win[8], win[13]))
		+ 5'(vote(win[6], win[5], win[4], win[1]))
		+ 5'(vote(win[6], win[5], win[14], win[11]))
		+ 5'(vote(win[6], win[5], win[2], win[7]));

	always_comb begin
		priority if (e96 && !e510) begin
			p1b = win[9];
			p2b = win[9];
		end else if (e510 && !e96) begin
			p1b = win[5];
			p2b = win[5];
		end else if (e510 && e96) begin
			priority if (votes > 5'sd0) p1b = win[6];
			else if (votes < 5'sd0) p1b = win[5];
			else p1b = hmix(win[5], win[6], hm, hl);
			p2b = p1b;
		end else begin
			priority if (win[6] == win[10] && win[10] == win[13] && win[9] != win[14]
				&& win[10] != win[12]) begin
				p2b = qmix(win[10], win[10], win[10], win[9], qm, ql);
			end else if (win[5] == win[9] && win[9] == win[14] && win[13] != win[10]
				&& win[9] != win[15]) begin
				p2b = qmix(win[9], win[9], win[9], win[10], qm, ql);
			end else begin
				p2b = hmix(win[9], win[10], hm, hl);
			end
			priority if (win[6] == win[10] && win[6] == win[1] && win[5] != win[2]
				&& win[6] != win[0]) begin
				p1b = qmix(win[6], win[6], win[6], win[5], qm, ql);
			end else if (win[5] == win[9] && win[5] == win[2] && win[1] != win[6]
				&& win[5] != win[3]) begin
				p1b = qmix(win[6], win[5], win[5], win[5], qm, ql);
			end else begin
				p1b = hmix(win[5], win[6], hm, hl);
			end
		end
	end

	always_comb begin
		if ((e510 && !e96 && win[4] == win[5] && win[5] != win[14])
			|| (win[5] == win[8] && win[6] == win[5] && win[4] != win[9]
			&& win[5] != win[12])) begin
			p2a = hmix(win[9], win[5], hm, hl);
		end else begin
			p2a = win[9];
		end
		if ((e96 && !e510 && win[8] == win[9] && win[9] != win[2])
			|| (win[4] == win[9] && win[10] == win[9] && win[8] != win[5]
			&& win[9] != win[0])) begin
			p1a = hmix(win[9], win[5], hm, hl);
		end else begin
			p1a = win[5];
		end
	end

endmodule

/* rtl/s2xs_front.sv */
// Window shifter, column counter and the emit stage that feeds the kernel.
// Depends on s2xs_pkg.
module s2xs_front #(
	parameter int MAX_WIDTH  = s2xs_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = s2xs_pkg::PIXEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  s2xs_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [3:0][PIXEL_BITS-1:0]  col,
	input  logic                        advance,
	output logic [15:0][PIXEL_BITS-1:0] win_s1,
	output s2xs_pkg::emit_ctl_t         ctl_s1
);

	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int CMP_W = ((CW > s2xs_pkg::ROW_WIDTH_W) ? CW : s2xs_pkg::ROW_WIDTH_W) + 1;
	localparam int XW    = (CW > s2xs_pkg::COL_W) ? CW : s2xs_pkg::COL_W;

	logic [15:0][PIXEL_BITS-1:0] window_q, win_next, win_rep;
	logic [CW-1:0]               count_q;
	logic [s2xs_pkg::COL_W-1:0]  col_s1;
	logic [1:0]                  extra_s1;
	logic                        flush_s1, valid_s1;

	logic [CMP_W-1:0] rw, w_eff;
	logic [XW-1:0]    k_minus2;
	logic             accept, is_last, emit;

	always_comb begin
		rw = CMP_W'(cfg.row_width);
		if (rw < CMP_W'(3)) w_eff = CMP_W'(3);
		else if (rw > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
		else w_eff = rw;
	end

	assign is_last  = CMP_W'(count_q) >= (w_eff - CMP_W'(1));
	assign emit     = is_last || (count_q >= CW'(2));
	assign k_minus2 = XW'(count_q) - XW'(2);

	assign in_stall = valid_s1 && !(advance && (extra_s1 == 2'd0));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				win_next[r*4+c] = (count_q == '0) ? col[r] : window_q[r*4+c+1];
				win_rep[r*4+c]  = win_s1[r*4+c+1];
			end
			win_next[r*4+3] = col[r];
			win_rep[r*4+3]  = win_s1[r*4+3];
		end
	end

	// window contents need no reset: the first column of a row overwrites all of it
	always_ff @(posedge clk) begin
		if (accept) window_q <= win_next;
		if (advance && extra_s1 != 2'd0) win_s1 <= win_rep;
		else if (accept && emit) win_s1 <= win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			col_s1   <= '0;
			extra_s1 <= 2'd0;
			flush_s1 <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) count_q <= is_last ? '0 : count_q + CW'(1);
			if (advance && extra_s1 != 2'd0) begin
				col_s1   <= col_s1 + s2xs_pkg::COL_W'(1);
				extra_s1 <= extra_s1 - 2'd1;
			end else if (accept && emit) begin
				col_s1   <= k_minus2[s2xs_pkg::COL_W-1:0];
				extra_s1 <= is_last ? 2'd2 : 2'd0;
				flush_s1 <= is_last;
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign ctl_s1.valid    = valid_s1;
	assign ctl_s1.column   = col_s1;
	assign ctl_s1.row_done = flush_s1 && (extra_s1 == 2'd0);

endmodule

/* rtl/super_2xsai_pixel_scaler.sv */
// Top level of the Super 2xSaI pixel scaler: config, front end, kernel, output register.
// Depends on s2xs_pkg, s2xs_cfg, s2xs_front, s2xs_kernel and the assertion header.
//
// Usage:
//   The input channel (in_valid / in_stall) takes one source column per request:
//   pixels of rows y-1, y, y+1, y+2. Columns of a row come left to right; the
//   counter restarts after the last column (row_width, clamped to 3..MAX_WIDTH).
//   The output channel (out_valid / out_stall) gives one 2x2 block per request
//   with its source column and a row_done flag on the last block of a row.
//   Columns 0 and 1 of a row give no block; column k >= 2 gives the block for
//   centre k-2; the last column gives three blocks (centres k-2, k-1, k).
//   A block passes through the emit stage and then the output register after its
//   column is taken. Throughput: one column per cycle while the output does not stall;
//   the last column of a row holds the input while the emit stage replays the right
//   edge for two more blocks.
//   A stall on the output holds the result register; the emit stage then
//   fills and in_stall rises, so nothing is lost.
//   Reset clears the counter, the pipeline valids and loads register defaults.
//   Configuration is written through cfg_write_en / cfg_index / cfg_data while idle.
`include "super_2xsai_pixel_scaler_defines.svh"
module super_2xsai_pixel_scaler #(
	parameter int MAX_WIDTH  = s2xs_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = s2xs_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [s2xs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [s2xs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [s2xs_pkg::PORT_PIX_W-1:0]     pixel_row_above,
	input  logic [s2xs_pkg::PORT_PIX_W-1:0]     pixel_row_centre,
	input  logic [s2xs_pkg::PORT_PIX_W-1:0]     pixel_row_below,
	input  logic [s2xs_pkg::PORT_PIX_W-1:0]     pixel_row_below_two,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [s2xs_pkg::PORT_PIX_W-1:0]     out_top_left,
	output logic [s2xs_pkg::PORT_PIX_W-1:0]     out_top_right,
	output logic [s2xs_pkg::PORT_PIX_W-1:0]     out_bottom_left,
	output logic [s2xs_pkg::PORT_PIX_W-1:0]     out_bottom_right,
	output logic [s2xs_pkg::COL_W-1:0]          out_column,
	output logic                                row_done
);

	localparam int PW = s2xs_pkg::PORT_PIX_W;

	s2xs_pkg::cfg_t              cfg;
	s2xs_pkg::emit_ctl_t         ctl_s1;
	logic [3:0][PIXEL_BITS-1:0]  col;
	logic [15:0][PIXEL_BITS-1:0] win_s1;
	logic [PIXEL_BITS-1:0]       p1a, p1b, p2a, p2b;
	logic                        advance;

	logic                        out_valid_q, row_done_q;
	logic [PW-1:0]               tl_q, tr_q, bl_q, br_q;
	logic [s2xs_pkg::COL_W-1:0]  column_q;

	assign col[0] = pixel_row_above[PIXEL_BITS-1:0];
	assign col[1] = pixel_row_centre[PIXEL_BITS-1:0];
	assign col[2] = pixel_row_below[PIXEL_BITS-1:0];
	assign col[3] = pixel_row_below_two[PIXEL_BITS-1:0];

	s2xs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	s2xs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.col      (col),
		.advance  (advance),
		.win_s1   (win_s1),
		.ctl_s1   (ctl_s1)
	);

	s2xs_kernel #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_kernel (
		.win (win_s1),
		.cfg (cfg),
		.p1a (p1a),
		.p1b (p1b),
		.p2a (p2a),
		.p2b (p2b)
	);

	assign advance   = ctl_s1.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (advance) begin
			tl_q       <= PW'(p1a);
			tr_q       <= PW'(p1b);
			bl_q       <= PW'(p2a);
			br_q       <= PW'(p2b);
			column_q   <= ctl_s1.column;
			row_done_q <= ctl_s1.row_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_top_left     = tl_q;
	assign out_top_right    = tr_q;
	assign out_bottom_left  = bl_q;
	assign out_bottom_right = br_q;
	assign out_column       = column_q;
	assign row_done         = row_done_q;

	`S2XS_ASSERT_IMP(a_empty_stage_takes, !ctl_s1.valid, !in_stall)
	`S2XS_ASSERT_NXT(a_free_out_fills, ctl_s1.valid && !out_valid_q, out_valid)
	`S2XS_ASSERT_IMP(a_out_from_stage, $rose(out_valid_q), $past(ctl_s1.valid))
	`S2XS_ASSERT_NXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_column))

endmodule

/* verif/tb.sv */
// Self-checking bench for the Super 2xSaI pixel scaler: a directed table of columns and
// register writes, then random rows, each block checked against a built-in Super 2xSaI predictor.
// Depends on s2xs_pkg and super_2xsai_pixel_scaler.
`timescale 1ns / 1ps

module tb;
	import s2xs_pkg::*;

	localparam int HANG_LIMIT = 200;
	localparam int RAND_ITEMS = 110;
	localparam logic [31:0] PX_A = 32'h5A3C_96E1;
	localparam logic [31:0] PX_B = 32'hA5C3_691E;

	typedef struct {
		logic [31:0]      tl;
		logic [31:0]      tr;
		logic [31:0]      bl;
		logic [31:0]      br;
		logic [COL_W-1:0] column;
		logic             last;
	} block_t;

	typedef enum logic {ST_COLUMN, ST_CONFIG} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic [31:0]          above;
		logic [31:0]          centre;
		logic [31:0]          below;
		logic [31:0]          below2;
		bit                   typed;
	} step_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PORT_PIX_W-1:0] pixel_row_above = '0;
	logic [PORT_PIX_W-1:0] pixel_row_centre = '0;
	logic [PORT_PIX_W-1:0] pixel_row_below = '0;
	logic [PORT_PIX_W-1:0] pixel_row_below_two = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PORT_PIX_W-1:0] out_top_left;
	logic [PORT_PIX_W-1:0] out_top_right;
	logic [PORT_PIX_W-1:0] out_bottom_left;
	logic [PORT_PIX_W-1:0] out_bottom_right;
	logic [COL_W-1:0] out_column;
	logic row_done;

	// typed expectation travels with the column request
	logic typed_px = 1'b0;
	logic [31:0] typed_val = '0;

	// predictor state
	logic [ROW_WIDTH_W-1:0] cfg_width = RST_ROW_WIDTH;
	logic [31:0] half_color = RST_HALF_COLOR;
	logic [31:0] half_low = RST_HALF_LOW;
	logic [31:0] quarter_color = RST_QUARTER_COLOR;
	logic [31:0] quarter_low = RST_QUARTER_LOW;
	logic [31:0] win [16] = '{default: '0};
	int unsigned col_cnt = 0;
	block_t blocks_due [$];

	int errors = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit rx_burst = 1'b0;
	bit tx_burst = 1'b0;

	super_2xsai_pixel_scaler u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write_en        (cfg_write_en),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.pixel_row_above     (pixel_row_above),
		.pixel_row_centre    (pixel_row_centre),
		.pixel_row_below     (pixel_row_below),
		.pixel_row_below_two (pixel_row_below_two),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.out_top_left        (out_top_left),
		.out_top_right       (out_top_right),
		.out_bottom_left     (out_bottom_left),
		.out_bottom_right    (out_bottom_right),
		.out_column          (out_column),
		.row_done            (row_done)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [31:0] half_avg(logic [31:0] a, logic [31:0] b);
		return ((a & half_color) >> 1) + ((b & half_color) >> 1) + (a & b & half_low);
	endfunction

	function automatic logic [31:0] quad_avg(logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		logic [31:0] hi;
		logic [33:0] lo;
		hi = ((a & quarter_color) >> 2) + ((b & quarter_color) >> 2)
			+ ((c & quarter_color) >> 2) + ((d & quarter_color) >> 2);
		lo = (a & quarter_low) + (b & quarter_low) + (c & quarter_low) + (d & quarter_low);
		return hi + 32'((lo >> 2) & {2'b00, quarter_low});
	endfunction

	function automatic int tie_vote(logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		int x;
		int y;
		int r;
		x = 0;
		y = 0;
		r = 0;
		if (a == c) x++; else if (b == c) y++;
		if (a == d) x++; else if (b == d) y++;
		if (x <= 1) r++;
		if (y <= 1) r--;
		return r;
	endfunction

	function automatic void slide_in(logic [31:0] c [4]);
		for (int r = 0; r < 4; r++) begin
			win[r*4]   = win[r*4+1];
			win[r*4+1] = win[r*4+2];
			win[r*4+2] = win[r*4+3];
			win[r*4+3] = c[r];
		end
	endfunction

	// 2x2 block for the centre pixel at win[5]
	function automatic void queue_block(int unsigned centre, bit last, bit typed,
			logic [31:0] flat);
		logic [31:0] w [16];
		logic [31:0] tl;
		logic [31:0] tr;
		logic [31:0] bl;
		logic [31:0] br;
		int score;
		block_t b;
		w = win;
		if (w[9] == w[6] && w[5] != w[10]) begin
			tr = w[9];
			br = w[9];
		end else if (w[5] == w[10] && w[9] != w[6]) begin
			tr = w[5];
			br = w[5];
		end else if (w[5] == w[10] && w[9] == w[6]) begin
			score = tie_vote(w[6], w[5], w[8], w[13]) + tie_vote(w[6], w[5], w[4], w[1])
				+ tie_vote(w[6], w[5], w[14], w[11]) + tie_vote(w[6], w[5], w[2], w[7]);
			if (score > 0) tr = w[6];
			else if (score < 0) tr = w[5];
			else tr = half_avg(w[5], w[6]);
			br = tr;
		end else begin
			if (w[6] == w[10] && w[10] == w[13] && w[9] != w[14] && w[10] != w[12])
				br = quad_avg(w[10], w[10], w[10], w[9]);
			else if (w[5] == w[9] && w[9] == w[14] && w[13] != w[10] && w[9] != w[15])
				br = quad_avg(w[9], w[9], w[9], w[10]);
			else
				br = half_avg(w[9], w[10]);
			if (w[6] == w[10] && w[6] == w[1] && w[5] != w[2] && w[6] != w[0])
				tr = quad_avg(w[6], w[6], w[6], w[5]);
			else if (w[5] == w[9] && w[5] == w[2] && w[1] != w[6] && w[5] != w[3])
				tr = quad_avg(w[6], w[5], w[5], w[5]);
			else
				tr = half_avg(w[5], w[6]);
		end
		if ((w[5] == w[10] && w[9] != w[6] && w[4] == w[5] && w[5] != w[14])
				|| (w[5] == w[8] && w[6] == w[5] && w[4] != w[9] && w[5] != w[12]))
			bl = half_avg(w[9], w[5]);
		else
			bl = w[9];
		if ((w[9] == w[6] && w[5] != w[10] && w[8] == w[9] && w[9] != w[2])
				|| (w[4] == w[9] && w[10] == w[9] && w[8] != w[5] && w[9] != w[0]))
			tl = half_avg(w[9], w[5]);
		else
			tl = w[5];
		if (typed) begin
			tl = flat;
			tr = flat;
			bl = flat;
			br = flat;
		end
		b.tl = tl;
		b.tr = tr;
		b.bl = bl;
		b.br = br;
		b.column = centre[COL_W-1:0];
		b.last = last;
		blocks_due.push_back(b);
	endfunction

	always @(posedge clk) begin : monitor
		bit took;
		int unsigned eff;
		int unsigned k;
		logic [31:0] cur [4];
		logic [31:0] rim [4];
		block_t due;
		if (arst_n) begin
			took = 1'b0;
			if (out_valid && !out_stall) begin
				took = 1'b1;
				if (blocks_due.size() == 0) begin
					$error("block for column %0d with no column request pending", out_column);
					errors++;
				end else begin
					due = blocks_due.pop_front();
					if (due.tl !== out_top_left) begin
						$error("out_top_left: expected %h, got %h", due.tl, out_top_left);
						errors++;
					end
					if (due.tr !== out_top_right) begin
						$error("out_top_right: expected %h, got %h", due.tr, out_top_right);
						errors++;
					end
					if (due.bl !== out_bottom_left) begin
						$error("out_bottom_left: expected %h, got %h", due.bl, out_bottom_left);
						errors++;
					end
					if (due.br !== out_bottom_right) begin
						$error("out_bottom_right: expected %h, got %h", due.br, out_bottom_right);
						errors++;
					end
					if (due.column !== out_column) begin
						$error("out_column: expected %0d, got %0d", due.column, out_column);
						errors++;
					end
					if (due.last !== row_done) begin
						$error("row_done: expected %b, got %b", due.last, row_done);
						errors++;
					end
				end
			end
			if (cfg_write_en) begin
				took = 1'b1;
				case (cfg_index)
					CFG_ROW_WIDTH: cfg_width = cfg_data[ROW_WIDTH_W-1:0];
					CFG_HALF_COLOR: half_color = cfg_data;
					CFG_HALF_LOW: half_low = cfg_data;
					CFG_QUARTER_COLOR: quarter_color = cfg_data;
					CFG_QUARTER_LOW: quarter_low = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				took = 1'b1;
				cur[0] = pixel_row_above;
				cur[1] = pixel_row_centre;
				cur[2] = pixel_row_below;
				cur[3] = pixel_row_below_two;
				eff = cfg_width;
				if (eff < 3) eff = 3;
				if (eff > MAX_WIDTH_DEF) eff = MAX_WIDTH_DEF;
				k = col_cnt;
				if (k == 0) begin
					for (int i = 0; i < 16; i++) win[i] = cur[i/4];
				end else begin
					slide_in(cur);
				end
				if (k >= eff - 1) begin
					queue_block(k - 2, 1'b0, typed_px, typed_val);
					for (int r = 0; r < 4; r++) rim[r] = win[r*4+3];
					slide_in(rim);
					queue_block(k - 1, 1'b0, typed_px, typed_val);
					slide_in(rim);
					queue_block(k, 1'b1, typed_px, typed_val);
					col_cnt = 0;
				end else begin
					if (k >= 2) queue_block(k - 2, 1'b0, typed_px, typed_val);
					col_cnt = k + 1;
				end
			end
			idle_cycles = took ? 0 : idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			hold_left = rx_burst ? 0 : $urandom_range(0, 8);
			if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0);
	end

	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < HANG_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic send_column(logic [31:0] a, logic [31:0] c, logic [31:0] b,
			logic [31:0] b2, bit typed, logic [31:0] flat);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_row_above <= a;
		pixel_row_centre <= c;
		pixel_row_below <= b;
		pixel_row_below_two <= b2;
		typed_px <= typed;
		typed_val <= flat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (blocks_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic step_t col_step(logic [31:0] a, logic [31:0] c, logic [31:0] b,
			logic [31:0] b2);
		step_t s;
		s.kind = ST_COLUMN;
		s.idx = '0;
		s.data = '0;
		s.above = a;
		s.centre = c;
		s.below = b;
		s.below2 = b2;
		s.typed = 1'b0;
		return s;
	endfunction

	// uniform column: every block of a uniform row equals its color
	function automatic step_t flat_step(logic [31:0] v);
		step_t s;
		s = col_step(v, v, v, v);
		s.typed = 1'b1;
		return s;
	endfunction

	function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
		step_t s;
		s = col_step('0, '0, '0, '0);
		s.kind = ST_CONFIG;
		s.idx = i;
		s.data = d;
		return s;
	endfunction

	initial begin
		step_t plan [$];
		int sent;
		int npal;
		int span;
		int unsigned w;
		logic [31:0] pal [4];
		logic [31:0] px [4];
		logic [31:0] d;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			col_step('0, '0, '0, '0),
			col_step('1, '1, '1, '1),
			col_step(PX_A, PX_B, PX_A, PX_B),
			col_step(PX_B, PX_A, PX_B, PX_A),
			cfg_step(CFG_ROW_WIDTH, 32'd2),
			col_step(PX_A, PX_B, PX_A, PX_B),
			flat_step('0), flat_step('0), flat_step('0),
			flat_step('1), flat_step('1), flat_step('1),
			cfg_step(CFG_HALF_COLOR, '1),
			cfg_step(CFG_HALF_LOW, '1),
			cfg_step(CFG_QUARTER_COLOR, '0),
			cfg_step(CFG_QUARTER_LOW, '1),
			col_step(PX_A, PX_A, PX_B, PX_A),
			col_step(PX_A, PX_B, PX_A, PX_A),
			col_step(PX_B, PX_A, PX_A, PX_B),
			cfg_step(CFG_ROW_WIDTH, '1),
			cfg_step(CFG_HALF_COLOR, '0),
			cfg_step(CFG_HALF_LOW, '0),
			cfg_step(CFG_QUARTER_COLOR, '1),
			cfg_step(CFG_QUARTER_LOW, '0),
			col_step(PX_A, PX_B, PX_B, PX_A),
			col_step(PX_B, PX_B, PX_A, PX_A),
			col_step(PX_A, PX_A, PX_A, PX_A),
			col_step(PX_B, PX_A, PX_A, PX_B),
			col_step(PX_A, PX_B, PX_B, PX_B),
			cfg_step(CFG_ROW_WIDTH, '0),
			col_step(PX_B, PX_B, PX_B, PX_B)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ST_CONFIG) begin
				wait_idle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_column(plan[i].above, plan[i].centre, plan[i].below, plan[i].below2,
					plan[i].typed, plan[i].centre);
			end
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			wait_idle();
			for (int i = CFG_ROW_WIDTH; i <= CFG_QUARTER_LOW; i++) begin
				if (i == CFG_ROW_WIDTH) begin
					case ($urandom_range(0, 9))
						0: w = $urandom_range(0, 2);
						1: w = MAX_WIDTH_DEF;
						2: w = 8191;
						3: w = $urandom_range(30, 60);
						default: w = $urandom_range(3, 10);
					endcase
					d = $urandom();
					d[ROW_WIDTH_W-1:0] = w[ROW_WIDTH_W-1:0];
				end else begin
					case ($urandom_range(0, 4))
						0: d = '0;
						1: d = '1;
						2: d = (i == CFG_HALF_COLOR) ? RST_HALF_COLOR :
							(i == CFG_HALF_LOW) ? RST_HALF_LOW :
							(i == CFG_QUARTER_COLOR) ? RST_QUARTER_COLOR : RST_QUARTER_LOW;
						default: d = $urandom();
					endcase
				end
				write_reg(CFG_IDX_W'(i), d);
			end
			span = $urandom_range(8, 30);
			if (span > RAND_ITEMS - sent) span = RAND_ITEMS - sent;
			npal = 2;
			for (int n = 0; n < span; n++) begin
				if (n % 4 == 0) begin
					npal = $urandom_range(2, 4);
					for (int p = 0; p < 4; p++)
						pal[p] = ($urandom_range(0, 5) == 0) ?
							($urandom_range(0, 1) ? '1 : '0) : $urandom();
				end
				for (int r = 0; r < 4; r++)
					px[r] = ($urandom_range(0, 7) == 0) ? $urandom() :
						pal[$urandom_range(0, npal - 1)];
				send_column(px[0], px[1], px[2], px[3], 1'b0, '0);
				sent++;
			end
		end
		wait_idle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/s2xs_pkg.sv
rtl/s2xs_cfg.sv
rtl/s2xs_kernel.sv
rtl/s2xs_front.sv
rtl/super_2xsai_pixel_scaler.sv
verif/tb.sv
